### rtl/ecda_pkg.sv
package ecda_pkg;

  localparam logic [1:0] KIND_EVENT = 2'd0;
  localparam logic [1:0] KIND_DECAY = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  localparam logic CFG_DECAY_RATE    = 1'b0;
  localparam logic CFG_CONTRAST_STEP = 1'b1;

  localparam logic [31:0] DECAY_RATE_RESET    = 32'd8590;
  localparam logic [23:0] CONTRAST_STEP_RESET = 24'd6554;

  localparam logic [4:0]  TAYLOR_LAST   = 5'd20;
  localparam logic [1:0]  SQUARE_LAST   = 2'd3;
  localparam logic [31:0] ONE_Q31       = 32'h8000_0000;
  localparam logic [16:0] FACTOR_ONE    = 17'h1_0000;
  localparam logic [31:0] EXP_LIMIT_HI  = 32'd12;

  typedef struct packed {
    logic       take;
    logic       clear_we;
    logic       ev_write;
    logic       out_load;
    logic       dc_mul;
    logic       dc_chk;
    logic       ty_mul;
    logic       div_start;
    logic       ty_acc;
    logic       sq_init;
    logic       sq_mul;
    logic       sq_rnd;
    logic       fact;
    logic       sweep_rd;
    logic       set_last;
    logic [4:0] term_k;
  } ecda_cmd_t;

  typedef struct packed {
    logic x_back;
    logic x_big;
    logic div_done;
    logic f_one;
    logic pipe_busy;
    logic out_full;
  } ecda_status_t;

endpackage

### rtl/ecda_item_if.sv
interface ecda_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  pixel_x;
  logic [7:0]  pixel_y;
  logic [31:0] event_time;
  logic        polarity;

  modport source (output valid, kind, pixel_x, pixel_y, event_time, polarity, input ready);
  modport sink (input valid, kind, pixel_x, pixel_y, event_time, polarity, output ready);
endinterface

### rtl/ecda_result_if.sv
interface ecda_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pixel_value;

  modport source (output valid, pixel_value, input ready);
  modport sink (input valid, pixel_value, output ready);
endinterface

### rtl/ecda_divider.sv
module ecda_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [4:0]  divisor,
  output logic        done,
  output logic [31:0] quotient
);
  logic [4:0] rem;
  logic [4:0] div_q;
  logic [5:0] cnt;
  logic       busy;
  logic [5:0] trial;

  assign trial = {rem, quotient[31]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 6'd0;
    end else begin
      done <= busy && (cnt == 6'd1);
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd32;
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= 5'd0;
      div_q    <= divisor;
    end else if (busy) begin
      if (trial >= {1'b0, div_q}) begin
        rem      <= 5'(trial - {1'b0, div_q});
        quotient <= {quotient[30:0], 1'b1};
      end else begin
        rem      <= trial[4:0];
        quotient <= {quotient[30:0], 1'b0};
      end
    end
  end
endmodule

### rtl/ecda_datapath.sv
module ecda_datapath #(
  parameter int IMAGE_WIDTH  = 256,
  parameter int IMAGE_HEIGHT = 256,
  parameter int ADDR_W       = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  ecda_pkg::ecda_cmd_t    cmd,
  output ecda_pkg::ecda_status_t status,
  input  logic [ADDR_W-1:0]      walk_addr,
  input  logic [1:0]             kind,
  input  logic [7:0]             pixel_x,
  input  logic [7:0]             pixel_y,
  input  logic [31:0]            event_time,
  input  logic                   polarity,
  input  logic                   cfg_we,
  input  logic                   cfg_index,
  input  logic [31:0]            cfg_data,
  input  logic                   out_ready,
  output logic                   out_valid,
  output logic signed [31:0]     out_pixel_value
);
  import ecda_pkg::*;

  localparam int Depth = IMAGE_WIDTH * IMAGE_HEIGHT;

  logic signed [31:0] mem [Depth];
  logic signed [31:0] rdata;
  logic [ADDR_W-1:0]  raddr;
  logic               we;
  logic [ADDR_W-1:0]  waddr;
  logic signed [31:0] wdata;

  logic [31:0] decay_rate;
  logic [23:0] contrast_step;
  logic [31:0] current_time;
  logic [31:0] last_decay_time;
  logic        time_started;

  logic [ADDR_W-1:0] item_addr;
  logic              item_in;
  logic              item_pol;
  logic [31:0]       idx_full;

  logic [63:0]        prod;
  logic               x_back;
  logic [31:0]        y_val;
  logic [31:0]        term;
  logic signed [33:0] sum;
  logic [31:0]        s_val;
  logic [16:0]        factor;
  logic               div_done;
  logic [31:0]        quot;

  logic               v1;
  logic               v2;
  logic [ADDR_W-1:0]  a1;
  logic [ADDR_W-1:0]  a2;
  logic [48:0]        sprod;
  logic               neg2;
  logic [31:0]        mag;
  logic [31:0]        r_mag;

  logic signed [33:0] ev_sum;
  logic signed [31:0] ev_sat;

  assign idx_full = 32'(pixel_y) * 32'(IMAGE_WIDTH) + 32'(pixel_x);

  always_ff @(posedge clk) begin
    if (rst) begin
      decay_rate    <= DECAY_RATE_RESET;
      contrast_step <= CONTRAST_STEP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DECAY_RATE:    decay_rate <= cfg_data;
        CFG_CONTRAST_STEP: contrast_step <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_time    <= 32'd0;
      last_decay_time <= 32'd0;
      time_started    <= 1'b0;
    end else if (cmd.take && kind == KIND_EVENT) begin
      current_time <= event_time;
      if (!time_started) begin
        last_decay_time <= event_time;
        time_started    <= 1'b1;
      end
    end else if (cmd.set_last) begin
      last_decay_time <= current_time;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      item_addr <= idx_full[ADDR_W-1:0];
      item_in   <= (32'(pixel_x) < 32'(IMAGE_WIDTH)) && (32'(pixel_y) < 32'(IMAGE_HEIGHT));
      item_pol  <= polarity;
    end
  end

  // event read-modify-write
  always_comb begin
    if (item_pol) begin
      ev_sum = 34'(rdata) - 34'(contrast_step);
    end else begin
      ev_sum = 34'(rdata) + 34'(contrast_step);
    end
    if (ev_sum > 34'sh0_7FFF_FFFF) begin
      ev_sat = 32'sh7FFF_FFFF;
    end else if (ev_sum < -34'sh0_8000_0000) begin
      ev_sat = 32'sh8000_0000;
    end else begin
      ev_sat = ev_sum[31:0];
    end
  end

  // decay factor
  always_ff @(posedge clk) begin
    if (cmd.dc_mul) begin
      prod   <= 64'(decay_rate) * 64'(current_time - last_decay_time);
      x_back <= current_time < last_decay_time;
      term   <= ONE_Q31;
      sum    <= 34'(ONE_Q31);
    end
    if (cmd.dc_chk) begin
      y_val  <= prod[35:4];
      factor <= 17'd0;
    end
    if (cmd.ty_mul) begin
      prod <= 64'(term) * 64'(y_val);
    end
    if (cmd.ty_acc) begin
      term <= quot;
      if (cmd.term_k[0]) begin
        sum <= sum - 34'(quot);
      end else begin
        sum <= sum + 34'(quot);
      end
    end
    if (cmd.sq_init) begin
      if (sum < 34'sd0) begin
        s_val <= 32'd0;
      end else if (sum > 34'(ONE_Q31)) begin
        s_val <= ONE_Q31;
      end else begin
        s_val <= sum[31:0];
      end
    end
    if (cmd.sq_mul) begin
      prod <= 64'(s_val) * 64'(s_val);
    end
    if (cmd.sq_rnd) begin
      s_val <= 32'((prod + 64'h4000_0000) >> 31);
    end
    if (cmd.fact) begin
      factor <= 17'((33'(s_val) + 33'h4000) >> 15);
    end
  end

  ecda_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (prod[63:32]),
    .divisor  (cmd.term_k),
    .done     (div_done),
    .quotient (quot)
  );

  // sweep pipeline
  assign mag   = rdata[31] ? 32'(-rdata) : 32'(rdata);
  assign r_mag = 32'((sprod + 49'h8000) >> 16);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= cmd.sweep_rd;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    a1    <= walk_addr;
    a2    <= a1;
    sprod <= 49'(mag) * 49'(factor);
    neg2  <= rdata[31];
  end

  // memory port
  assign raddr = cmd.sweep_rd ? walk_addr : item_addr;

  always_comb begin
    we    = 1'b0;
    waddr = item_addr;
    wdata = ev_sat;
    if (cmd.clear_we) begin
      we    = 1'b1;
      waddr = walk_addr;
      wdata = 32'sd0;
    end else if (v2) begin
      we    = 1'b1;
      waddr = a2;
      wdata = neg2 ? -$signed(r_mag) : $signed(r_mag);
    end else if (cmd.ev_write && item_in) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_pixel_value <= item_in ? rdata : 32'sd0;
    end
  end

  assign status.x_back    = x_back;
  assign status.x_big     = prod[63:32] >= EXP_LIMIT_HI;
  assign status.div_done  = div_done;
  assign status.f_one     = factor == FACTOR_ONE;
  assign status.pipe_busy = v1 | v2;
  assign status.out_full  = out_valid & ~out_ready;
endmodule

### rtl/ecda_ctrl.sv
module ecda_ctrl #(
  parameter int IMAGE_WIDTH  = 256,
  parameter int IMAGE_HEIGHT = 256,
  parameter int ADDR_W       = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  input  logic [1:0]             item_kind,
  output logic                   item_ready,
  input  ecda_pkg::ecda_status_t status,
  output ecda_pkg::ecda_cmd_t    cmd,
  output logic [ADDR_W-1:0]      walk_addr
);
  import ecda_pkg::*;

  localparam int Depth = IMAGE_WIDTH * IMAGE_HEIGHT;
  localparam logic [ADDR_W-1:0] LastAddr = ADDR_W'(Depth - 1);

  typedef enum logic [19:0] {
    S_CLEAR    = 20'h00001,
    S_IDLE     = 20'h00002,
    S_EV_RD    = 20'h00004,
    S_EV_WR    = 20'h00008,
    S_RD_RD    = 20'h00010,
    S_RD_OUT   = 20'h00020,
    S_DC_MUL   = 20'h00040,
    S_DC_CHK   = 20'h00080,
    S_TY_MUL   = 20'h00100,
    S_TY_START = 20'h00200,
    S_TY_DIV   = 20'h00400,
    S_TY_ACC   = 20'h00800,
    S_SQ_INIT  = 20'h01000,
    S_SQ_MUL   = 20'h02000,
    S_SQ_RND   = 20'h04000,
    S_FACT     = 20'h08000,
    S_FCHK     = 20'h10000,
    S_SWEEP    = 20'h20000,
    S_DRAIN    = 20'h40000,
    S_FINISH   = 20'h80000
  } state_t;

  state_t            state;
  state_t            state_next;
  logic [ADDR_W-1:0] cnt;
  logic [ADDR_W-1:0] cnt_next;
  logic [4:0]        k;
  logic [4:0]        k_next;
  logic [1:0]        j;
  logic [1:0]        j_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      cnt   <= '0;
      k     <= 5'd1;
      j     <= 2'd0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      k     <= k_next;
      j     <= j_next;
    end
  end

  assign walk_addr  = cnt;
  assign item_ready = state == S_IDLE;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    k_next     = k;
    j_next     = j;
    cmd        = '0;
    cmd.term_k = k;
    case (state)
      S_CLEAR: begin
        cmd.clear_we = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == LastAddr) begin
          cnt_next   = '0;
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (item_valid) begin
          cmd.take = 1'b1;
          case (item_kind)
            KIND_EVENT: state_next = S_EV_RD;
            KIND_DECAY: state_next = S_DC_MUL;
            KIND_READ:  state_next = S_RD_RD;
            default:    state_next = S_IDLE;
          endcase
        end
      end
      S_EV_RD: state_next = S_EV_WR;
      S_EV_WR: begin
        cmd.ev_write = 1'b1;
        state_next   = S_IDLE;
      end
      S_RD_RD: state_next = S_RD_OUT;
      S_RD_OUT: begin
        if (!status.out_full) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_DC_MUL: begin
        cmd.dc_mul = 1'b1;
        k_next     = 5'd1;
        j_next     = 2'd0;
        state_next = S_DC_CHK;
      end
      S_DC_CHK: begin
        cmd.dc_chk = 1'b1;
        if (status.x_back) begin
          state_next = S_FINISH;
        end else if (status.x_big) begin
          state_next = S_SWEEP;
        end else begin
          state_next = S_TY_MUL;
        end
      end
      S_TY_MUL: begin
        cmd.ty_mul = 1'b1;
        state_next = S_TY_START;
      end
      S_TY_START: begin
        cmd.div_start = 1'b1;
        state_next    = S_TY_DIV;
      end
      S_TY_DIV: begin
        if (status.div_done) begin
          state_next = S_TY_ACC;
        end
      end
      S_TY_ACC: begin
        cmd.ty_acc = 1'b1;
        k_next     = k + 5'd1;
        state_next = (k == TAYLOR_LAST) ? S_SQ_INIT : S_TY_MUL;
      end
      S_SQ_INIT: begin
        cmd.sq_init = 1'b1;
        state_next  = S_SQ_MUL;
      end
      S_SQ_MUL: begin
        cmd.sq_mul = 1'b1;
        state_next = S_SQ_RND;
      end
      S_SQ_RND: begin
        cmd.sq_rnd = 1'b1;
        j_next     = j + 2'd1;
        state_next = (j == SQUARE_LAST) ? S_FACT : S_SQ_MUL;
      end
      S_FACT: begin
        cmd.fact   = 1'b1;
        state_next = S_FCHK;
      end
      S_FCHK: state_next = status.f_one ? S_FINISH : S_SWEEP;
      S_SWEEP: begin
        cmd.sweep_rd = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == LastAddr) begin
          cnt_next   = '0;
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!status.pipe_busy) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        cmd.set_last = 1'b1;
        state_next   = S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
  end
endmodule

### rtl/event_camera_decay_accumulator.sv
// event camera decay accumulator: per-pixel log intensity store with global decay
// item_ch takes one item per beat (kind: event, decay or read); result_ch returns
// one beat per read item with the signed Q15.16 pixel value (0 outside the image).
// config: cfg_we writes cfg_data into register cfg_index (0 decay_rate,
// 1 contrast_step); write only while the block is idle.
// item_ch.ready is high only while the controller sits idle, one item at a time.
// event: accept, store read, saturating write back.
// read: accept, store read, result register; it waits there while result_ch stalls,
// and the block holds the next item until the register is free.
// decay: DC_MUL and DC_CHK, 20 Taylor terms (each waits on a bit-serial
// divider), SQ_INIT, the squarings and FACT give the factor, then one store entry
// per cycle through a 3-stage read-multiply-write sweep, then S_FINISH updates
// the last decay time; a large exponent goes straight to the sweep, time going
// backwards or a factor of one skips the sweep.
// reset: synchronous; afterwards a clearing pass writes zero to every entry with
// item_ch.ready low; config writes still work.
module event_camera_decay_accumulator #(
  parameter int IMAGE_WIDTH  = 256,
  parameter int IMAGE_HEIGHT = 256
) (
  input  logic          clk,
  input  logic          rst,
  ecda_item_if.sink     item_ch,
  ecda_result_if.source result_ch,
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic [31:0]   cfg_data
);
  import ecda_pkg::*;

  localparam int Depth  = IMAGE_WIDTH * IMAGE_HEIGHT;
  localparam int ADDR_W = (Depth > 1) ? $clog2(Depth) : 1;

  ecda_cmd_t         cmd;
  ecda_status_t      status;
  logic [ADDR_W-1:0] walk_addr;

  ecda_ctrl #(
    .IMAGE_WIDTH  (IMAGE_WIDTH),
    .IMAGE_HEIGHT (IMAGE_HEIGHT),
    .ADDR_W       (ADDR_W)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_ch.valid),
    .item_kind  (item_ch.kind),
    .item_ready (item_ch.ready),
    .status     (status),
    .cmd        (cmd),
    .walk_addr  (walk_addr)
  );

  ecda_datapath #(
    .IMAGE_WIDTH  (IMAGE_WIDTH),
    .IMAGE_HEIGHT (IMAGE_HEIGHT),
    .ADDR_W       (ADDR_W)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .walk_addr       (walk_addr),
    .kind            (item_ch.kind),
    .pixel_x         (item_ch.pixel_x),
    .pixel_y         (item_ch.pixel_y),
    .event_time      (item_ch.event_time),
    .polarity        (item_ch.polarity),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_ready       (result_ch.ready),
    .out_valid       (result_ch.valid),
    .out_pixel_value (result_ch.pixel_value)
  );

  a_idle_no_sweep: assert property (@(posedge clk) disable iff (rst)
    item_ch.ready |-> !status.pipe_busy)
    else $error("item taken while sweep pipeline busy");

  a_load_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !(result_ch.valid && !result_ch.ready))
    else $error("result register overwritten");

  a_clear_blocks_items: assert property (@(posedge clk) disable iff (rst)
    cmd.clear_we |-> !item_ch.ready)
    else $error("item accepted during clearing pass");
endmodule

### tb/ecda_tb_if.sv
`timescale 1ns / 1ps

interface ecda_cfg_if;
  logic        cfg_we;
  logic        cfg_index;
  logic [31:0] cfg_data;
endinterface

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import ecda_pkg::*;

  localparam int IMG_W = 16;
  localparam int IMG_H = 8;
  localparam int NPIX = IMG_W * IMG_H;
  localparam int DECAY_WAIT = 2500;
  localparam longint CYCLE_LIMIT = 3000000;

  typedef struct {
    logic [1:0]  kind;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [31:0] t;
    logic        pol;
    bit          typed;
    logic signed [31:0] val;
  } row_t;

  logic clk = 0;
  logic rst = 1;
  ecda_item_if   item_bus();
  ecda_result_if res_bus();
  ecda_cfg_if    cfg_bus();

  event_camera_decay_accumulator #(.IMAGE_WIDTH(IMG_W), .IMAGE_HEIGHT(IMG_H)) dut (
    .clk(clk), .rst(rst), .item_ch(item_bus), .result_ch(res_bus),
    .cfg_we(cfg_bus.cfg_we), .cfg_index(cfg_bus.cfg_index), .cfg_data(cfg_bus.cfg_data)
  );

  always #4 clk = ~clk;

  // predictor state
  logic signed [31:0] intensity [NPIX];
  logic [31:0] now_time, last_time, rate;
  logic [23:0] step;
  bit started;
  logic signed [31:0] pending_pixels[$];

  int errors = 0;
  int mode = 0;
  int sent = 0;
  longint cycles = 0;
  bit held_once = 0;
  int hold_left = 0;

  function automatic logic [16:0] decay_gain();
    logic [63:0] d, x, y, term, s;
    longint acc;
    if (now_time < last_time) return FACTOR_ONE;
    d = 64'(now_time - last_time);
    x = 64'(rate) * d;
    if (x >= (64'd12 << 32)) return 17'd0;
    y = x >> 4;
    term = 64'(ONE_Q31);
    acc = longint'(64'(ONE_Q31));
    for (int k = 1; k <= 20; k++) begin
      term = ((term * y) >> 32) / 64'(k);
      if (k % 2 == 1) acc -= longint'(term);
      else acc += longint'(term);
    end
    if (acc < 0) acc = 0;
    s = 64'(acc);
    if (s > 64'(ONE_Q31)) s = 64'(ONE_Q31);
    for (int k = 0; k < 4; k++) s = (s * s + (64'd1 << 30)) >> 31;
    return 17'((s + (64'd1 << 14)) >> 15);
  endfunction

  function automatic logic signed [31:0] scale_px(logic signed [31:0] p, logic [16:0] f);
    longint pv;
    logic [63:0] mag, r;
    pv = p;
    mag = (pv < 0) ? 64'(-pv) : 64'(pv);
    r = (mag * 64'(f) + 64'd32768) >> 16;
    return (pv < 0) ? 32'(-longint'(r)) : 32'(r);
  endfunction

  function automatic bit in_image(logic [7:0] x, logic [7:0] y);
    return (x < IMG_W) && (y < IMG_H);
  endfunction

  // returns 1 and the value when the item produces a read beat
  function automatic bit apply_item(row_t r, output logic signed [31:0] v);
    longint acc;
    logic [16:0] f;
    int idx;
    v = 0;
    idx = int'(r.y) * IMG_W + int'(r.x);
    case (r.kind)
      KIND_EVENT: begin
        if (!started) begin
          last_time = r.t;
          started = 1;
        end
        now_time = r.t;
        if (in_image(r.x, r.y)) begin
          acc = intensity[idx];
          if (r.pol) acc -= longint'(step);
          else acc += longint'(step);
          if (acc > 64'sd2147483647) acc = 64'sd2147483647;
          if (acc < -64'sd2147483648) acc = -64'sd2147483648;
          intensity[idx] = 32'(acc);
        end
        return 0;
      end
      KIND_DECAY: begin
        f = decay_gain();
        if (f != FACTOR_ONE)
          for (int i = 0; i < NPIX; i++) intensity[i] = scale_px(intensity[i], f);
        last_time = now_time;
        return 0;
      end
      KIND_READ: begin
        if (in_image(r.x, r.y)) v = intensity[idx];
        return 1;
      end
      default: return 0;
    endcase
  endfunction

  task automatic send_item(row_t r);
    logic signed [31:0] v;
    bit acc;
    int idle_pct;
    item_bus.valid <= 1;
    item_bus.kind <= r.kind;
    item_bus.pixel_x <= r.x;
    item_bus.pixel_y <= r.y;
    item_bus.event_time <= r.t;
    item_bus.polarity <= r.pol;
    do begin
      @(negedge clk);
      acc = item_bus.ready;
      @(posedge clk);
    end while (!acc);
    if (apply_item(r, v)) pending_pixels.push_back(r.typed ? r.val : v);
    sent++;
    mode = (sent < 280) ? 0 : (sent < 560) ? 1 : 2;
    idle_pct = (mode == 0) ? 14 : (mode == 1) ? 87 : 0;
    if ($urandom_range(0, 99) < idle_pct) begin
      item_bus.valid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic drain();
    item_bus.valid <= 0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DECAY_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] data);
    cfg_bus.cfg_we <= 1;
    cfg_bus.cfg_index <= idx;
    cfg_bus.cfg_data <= data;
    @(posedge clk);
    cfg_bus.cfg_we <= 0;
    if (idx == CFG_DECAY_RATE) rate = data;
    else step = data[23:0];
  endtask

  task automatic random_items(int n, int pol_bias, int decay_pct);
    row_t r;
    logic [31:0] t_now;
    int pick;
    t_now = now_time;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      r.kind = (pick < 2) ? 2'd3 : (pick < 2 + decay_pct) ? KIND_DECAY :
               (pick < 35) ? KIND_READ : KIND_EVENT;
      pick = $urandom_range(0, 99);
      if (pick < 5) t_now = $urandom;
      else if (pick < 8) t_now = t_now - $urandom_range(1, 100);
      else t_now = t_now + $urandom_range(0, 40);
      r.t = t_now;
      if ($urandom_range(0, 9) == 0) begin
        r.x = $urandom_range(0, 255);
        r.y = $urandom_range(0, 255);
      end else if ($urandom_range(0, 2) == 0) begin
        r.x = $urandom_range(0, 1);
        r.y = 0;
      end else begin
        r.x = $urandom_range(0, IMG_W - 1);
        r.y = $urandom_range(0, IMG_H - 1);
      end
      r.pol = ($urandom_range(0, 99) < pol_bias);
      r.typed = 0;
      r.val = 0;
      send_item(r);
    end
  endtask

  row_t directed [] = '{
    '{KIND_READ,   8'd0,   8'd0,   32'd0,          1'b0, 1, 32'sd0},
    '{KIND_READ,   8'd255, 8'd255, 32'hFFFF_FFFF,  1'b1, 1, 32'sd0},
    '{KIND_DECAY,  8'd0,   8'd0,   32'd0,          1'b0, 0, 32'sd0},
    '{KIND_EVENT,  8'd0,   8'd0,   32'd100,        1'b1, 0, 32'sd0},
    '{KIND_EVENT,  8'd15,  8'd7,   32'd100,        1'b0, 0, 32'sd0},
    '{KIND_EVENT,  8'd255, 8'd255, 32'd100,        1'b1, 0, 32'sd0},
    '{KIND_READ,   8'd0,   8'd0,   32'd0,          1'b0, 1, -32'sd6554},
    '{KIND_READ,   8'd15,  8'd7,   32'd0,          1'b0, 1, 32'sd6554},
    '{2'd3,        8'd0,   8'd0,   32'd5,          1'b1, 0, 32'sd0},
    '{KIND_READ,   8'd0,   8'd0,   32'd0,          1'b0, 1, -32'sd6554},
    '{KIND_EVENT,  8'd3,   8'd3,   32'hFFFF_FFF0,  1'b0, 0, 32'sd0},
    '{KIND_DECAY,  8'd0,   8'd0,   32'd0,          1'b0, 0, 32'sd0},
    '{KIND_READ,   8'd0,   8'd0,   32'd0,          1'b0, 1, 32'sd0},
    '{KIND_EVENT,  8'd1,   8'd1,   32'd50,         1'b1, 0, 32'sd0},
    '{KIND_DECAY,  8'd0,   8'd0,   32'd0,          1'b0, 0, 32'sd0},
    '{KIND_READ,   8'd1,   8'd1,   32'd0,          1'b0, 1, -32'sd6554},
    '{KIND_EVENT,  8'd1,   8'd1,   32'd60,         1'b0, 0, 32'sd0},
    '{KIND_EVENT,  8'd1,   8'd1,   32'd200000,     1'b0, 0, 32'sd0},
    '{KIND_DECAY,  8'd0,   8'd0,   32'd0,          1'b0, 0, 32'sd0},
    '{KIND_READ,   8'd1,   8'd1,   32'd0,          1'b0, 0, 32'sd0},
    '{KIND_READ,   8'd2,   8'd2,   32'd0,          1'b0, 1, 32'sd0}
  };

  initial begin
    row_t r;
    item_bus.valid = 0;
    item_bus.kind = KIND_EVENT;
    item_bus.pixel_x = 0;
    item_bus.pixel_y = 0;
    item_bus.event_time = 0;
    item_bus.polarity = 0;
    cfg_bus.cfg_we = 0;
    cfg_bus.cfg_index = CFG_DECAY_RATE;
    cfg_bus.cfg_data = 0;
    foreach (intensity[i]) intensity[i] = 0;
    now_time = 0;
    last_time = 0;
    started = 0;
    rate = DECAY_RATE_RESET;
    step = CONTRAST_STEP_RESET;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    foreach (directed[i]) send_item(directed[i]);
    drain();

    // saturation at the extremes
    write_reg(CFG_DECAY_RATE, 32'hFFFF_FFFF);
    write_reg(CFG_CONTRAST_STEP, 32'h00FF_FFFF);
    r.typed = 0;
    r.val = 0;
    r.t = now_time;
    for (int i = 0; i < 260; i++) begin
      r.kind = KIND_EVENT;
      r.x = i % 2;
      r.y = 0;
      r.pol = (i % 2 == 0);
      send_item(r);
    end
    r.kind = KIND_READ;
    r.x = 0;
    r.pol = 0;
    r.typed = 1;
    r.val = 32'sh8000_0000;
    send_item(r);
    r.x = 1;
    r.val = 32'sh7FFF_FFFF;
    send_item(r);
    random_items(100, 90, 4);
    drain();

    write_reg(CFG_DECAY_RATE, 32'd0);
    write_reg(CFG_CONTRAST_STEP, 32'd0);
    random_items(90, 50, 5);
    drain();

    write_reg(CFG_DECAY_RATE, $urandom_range(1 << 18, 1 << 27));
    write_reg(CFG_CONTRAST_STEP, $urandom_range(1, 1 << 20));
    random_items(110, 10, 5);
    drain();

    write_reg(CFG_DECAY_RATE, DECAY_RATE_RESET);
    write_reg(CFG_CONTRAST_STEP, $urandom_range(1 << 16, 1 << 23));
    random_items(120, 50, 5);
    drain();

    if (errors == 0) $display("event_camera_decay_accumulator: match");
    else $display("event_camera_decay_accumulator: mismatch");
    $finish;
  end

  // receiver with a long hold-off once in the last idling mode
  initial res_bus.ready = 0;
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      res_bus.ready <= 0;
    end else if (mode == 2 && !held_once) begin
      held_once <= 1;
      hold_left <= 400;
      res_bus.ready <= 0;
    end else begin
      res_bus.ready <= ($urandom_range(0, 99) >= ((mode == 0) ? 87 : (mode == 1) ? 14 : 0));
    end
  end

  initial begin
    logic signed [31:0] got, want;
    forever begin
      @(negedge clk);
      if (res_bus.valid && res_bus.ready) begin
        got = res_bus.pixel_value;
        @(posedge clk);
        if (pending_pixels.size() == 0) begin
          errors++;
          $display("%0t unexpected beat: expected none, actual %0d", $time, got);
        end else begin
          want = pending_pixels.pop_front();
          if (got !== want) begin
            errors++;
            $display("%0t pixel_value: expected %0d, actual %0d", $time, want, got);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("event_camera_decay_accumulator: mismatch");
      $finish;
    end
  end
endmodule
